[rtl/gbrf_pkg.sv]
`default_nettype none
package gbrf_pkg;

  typedef struct packed {
    logic signed [23:0] yaw_target;
    logic signed [23:0] pitch_target;
    logic signed [31:0] yaw_feedback_rev;
    logic signed [31:0] pitch_feedback_rev;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        yaw_steps;
    logic               yaw_negative;
    logic [15:0]        pitch_steps;
    logic               pitch_negative;
    logic               report_due;
    logic signed [15:0] report_yaw;
    logic signed [15:0] report_pitch;
  } out_item_t;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_ALPHA     = 3'd0;
  localparam logic [2:0] CFG_PPD       = 3'd1;
  localparam logic [2:0] CFG_YAW_LIM   = 3'd2;
  localparam logic [2:0] CFG_PITCH_LIM = 3'd3;
  localparam logic [2:0] CFG_PERIOD    = 3'd4;

  localparam logic [15:0] ALPHA_RESET     = 16'd9830;
  localparam logic [23:0] PPD_RESET       = 24'd582542;
  localparam logic [14:0] YAW_LIM_RESET   = 15'd30720;
  localparam logic [14:0] PITCH_LIM_RESET = 15'd23040;
  localparam logic [7:0]  PERIOD_RESET    = 8'd5;

  // multiplier bit counts per operation
  localparam logic [4:0] MUL_N_LP     = 5'd16;
  localparam logic [4:0] MUL_N_PULSE  = 5'd24;
  localparam logic [4:0] MUL_N_REPORT = 5'd9;

  // 360 degrees per revolution
  localparam logic [23:0] REPORT_SCALE = 24'd360;

  typedef enum logic [1:0] {
    OP_LP     = 2'd0,
    OP_PULSE  = 2'd1,
    OP_REPORT = 2'd2
  } op_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic first;
    op_t  op;
  } axis_ctrl_t;

endpackage
`default_nettype wire

[rtl/gbrf_mul.sv]
`default_nettype none
module gbrf_mul
  import gbrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [23:0] b,
  input  wire logic [4:0]  nbits,
  output logic             done,
  output logic [31:0]      prod_hi,
  output logic [23:0]      prod_lo
);

  logic [31:0] u_r, u_nxt;
  logic [23:0] l_r, l_nxt;
  logic [31:0] a_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sum;

  // shift-add, multiplier bits leave l_r lsb first, product bits enter at its top
  always_comb begin
    sum      = {1'b0, u_r} + (l_r[0] ? {1'b0, a_r} : 33'd0);
    u_nxt    = u_r;
    l_nxt    = l_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      u_nxt    = 32'd0;
      l_nxt    = b;
      cnt_nxt  = nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      u_nxt   = sum[32:1];
      l_nxt   = {sum[0], l_r[23:1]};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    l_r <= l_nxt;
    if (start) begin
      a_r <= a;
    end
  end

  assign done    = done_r;
  assign prod_hi = u_r;
  assign prod_lo = l_r;

endmodule
`default_nettype wire

[rtl/gbrf_axis.sv]
`default_nettype none
module gbrf_axis
  import gbrf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire axis_ctrl_t         ctrl,
  input  wire logic               invert,
  input  wire logic [14:0]        lim,
  input  wire logic [15:0]        alpha,
  input  wire logic [23:0]        ppd,
  input  wire logic signed [23:0] target,
  input  wire logic signed [31:0] feedback,
  output logic                    done,
  output logic [15:0]             steps,
  output logic                    negative,
  output logic signed [15:0]      report
);

  logic signed [15:0] tgt_r;
  logic signed [31:0] fb_r;
  logic signed [24:0] filt_r;
  logic               sign_r, sign_nxt;
  logic [15:0]        steps_r;
  logic               neg_r;
  logic signed [15:0] rep_r;

  logic signed [24:0] t_ext, lim_ext, lim_neg;
  logic signed [15:0] t_clamp;
  logic signed [25:0] d;
  logic [25:0]        d_mag;
  logic [24:0]        filt_mag;
  logic [31:0]        fb_mag;

  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [4:0]  mul_n;
  logic        mul_done;
  logic [31:0] mul_hi;
  logic [23:0] mul_lo;

  logic [32:0]        lp_r;
  logic signed [26:0] lp_delta, lp_sum;
  logic [23:0]        pu_r;
  logic [15:0]        pu_sat;
  logic               pu_neg;
  logic [33:0]        rp_r;
  logic [14:0]        rp_mag;
  logic signed [15:0] rp_val;

  always_comb begin
    t_ext   = {target[23], target};
    lim_ext = {10'd0, lim};
    lim_neg = -lim_ext;
    if (t_ext > lim_ext) begin
      t_clamp = lim_ext[15:0];
    end else if (t_ext < lim_neg) begin
      t_clamp = lim_neg[15:0];
    end else begin
      t_clamp = t_ext[15:0];
    end
  end

  always_comb begin
    d        = {tgt_r[15], tgt_r, 9'd0} - {filt_r[24], filt_r};
    d_mag    = d[25] ? 26'(-d) : 26'(d);
    filt_mag = filt_r[24] ? 25'(-filt_r) : 25'(filt_r);
    fb_mag   = fb_r[31] ? 32'(-fb_r) : 32'(fb_r);
    case (ctrl.op)
      OP_LP: begin
        mul_a    = {6'd0, d_mag};
        mul_b    = {8'd0, alpha};
        mul_n    = MUL_N_LP;
        sign_nxt = d[25];
      end
      OP_PULSE: begin
        mul_a    = {7'd0, filt_mag};
        mul_b    = ppd;
        mul_n    = MUL_N_PULSE;
        sign_nxt = filt_r[24] ^ invert;
      end
      OP_REPORT: begin
        mul_a    = fb_mag;
        mul_b    = REPORT_SCALE;
        mul_n    = MUL_N_REPORT;
        sign_nxt = fb_r[31] ^ invert;
      end
      default: begin
        mul_a    = 32'd0;
        mul_b    = 24'd0;
        mul_n    = MUL_N_REPORT;
        sign_nxt = 1'b0;
      end
    endcase
  end

  gbrf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctrl.start),
    .a       (mul_a),
    .b       (mul_b),
    .nbits   (mul_n),
    .done    (mul_done),
    .prod_hi (mul_hi),
    .prod_lo (mul_lo)
  );

  // round half away from zero on magnitudes: floor plus the first dropped bit
  always_comb begin
    lp_r     = {1'b0, mul_hi} + 33'(mul_lo[23]);
    lp_delta = sign_r ? -$signed({1'b0, lp_r[25:0]}) : $signed({1'b0, lp_r[25:0]});
    lp_sum   = {{2{filt_r[24]}}, filt_r} + lp_delta;

    pu_r   = {1'b0, mul_hi[31:9]} + 24'(mul_hi[8]);
    pu_sat = (|pu_r[23:16]) ? 16'hFFFF : pu_r[15:0];
    pu_neg = sign_r & (|pu_r);

    rp_r   = {1'b0, mul_hi, mul_lo[23]} + 34'(mul_lo[22]);
    rp_mag = (rp_r > {19'd0, lim}) ? lim : rp_r[14:0];
    rp_val = sign_r ? -$signed({1'b0, rp_mag}) : $signed({1'b0, rp_mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= 25'sd0;
    end else if (mul_done && ctrl.op == OP_LP) begin
      filt_r <= ctrl.first ? {tgt_r, 9'd0} : lp_sum[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      tgt_r <= t_clamp;
      fb_r  <= feedback;
    end
    if (ctrl.start) begin
      sign_r <= sign_nxt;
    end
    if (mul_done) begin
      case (ctrl.op)
        OP_PULSE: begin
          steps_r <= pu_sat;
          neg_r   <= pu_neg;
        end
        OP_REPORT: rep_r <= rp_val;
        default: ;
      endcase
    end
  end

  assign done     = mul_done;
  assign steps    = steps_r;
  assign negative = neg_r;
  assign report   = rep_r;

endmodule
`default_nettype wire

[rtl/two_axis_gimbal_reference_filter.sv]
`default_nettype none
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (in_item_t)
// out      output     out_valid / out_ready  out_data  (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a result is loaded into the output register once its request's passes are through; a new
// request is taken only back in idle, after the last result is written: per axis three
// bit-serial shift-add passes (16, 24, 9 bits), axes in parallel, then the output load
// synchronous active-low reset restores register defaults and clears the filter
// a finished result waits in the output register; the next request is taken
// meanwhile, and only the final write waits for that register to free up
module two_axis_gimbal_reference_filter
  import gbrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LP    = 8'b0000_0010,
    S_LP_W  = 8'b0000_0100,
    S_PU    = 8'b0000_1000,
    S_PU_W  = 8'b0001_0000,
    S_RP    = 8'b0010_0000,
    S_RP_W  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] alpha_r;
  logic [23:0] ppd_r;
  logic [14:0] ylim_r, plim_r;
  logic [7:0]  period_r;

  logic [7:0] tick_r, tick_inc;
  logic       due_r, due_nxt;
  logic       loaded_r;
  logic       out_valid_r;
  out_item_t  out_r;

  axis_ctrl_t ctrl;
  logic       y_done, p_done;
  logic [15:0] y_steps, p_steps;
  logic        y_neg, p_neg;
  logic signed [15:0] y_rep, p_rep;

  logic accept, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RESET;
      ppd_r    <= PPD_RESET;
      ylim_r   <= YAW_LIM_RESET;
      plim_r   <= PITCH_LIM_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHA:     alpha_r  <= cfg_data[15:0];
        CFG_PPD:       ppd_r    <= cfg_data;
        CFG_YAW_LIM:   ylim_r   <= cfg_data[14:0];
        CFG_PITCH_LIM: plim_r   <= cfg_data[14:0];
        CFG_PERIOD:    period_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_inc = tick_r + 8'd1;
    due_nxt  = (tick_inc >= period_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_LP;
      S_LP:    state_nxt = S_LP_W;
      S_LP_W:  if (y_done) state_nxt = S_PU;
      S_PU:    state_nxt = S_PU_W;
      S_PU_W:  if (y_done) state_nxt = S_RP;
      S_RP:    state_nxt = S_RP_W;
      S_RP_W:  if (y_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.capture = accept;
    ctrl.start   = (state_r == S_LP) || (state_r == S_PU) || (state_r == S_RP);
    ctrl.first   = !loaded_r;
    if (state_r == S_PU || state_r == S_PU_W) begin
      ctrl.op = OP_PULSE;
    end else if (state_r == S_RP || state_r == S_RP_W) begin
      ctrl.op = OP_REPORT;
    end else begin
      ctrl.op = OP_LP;
    end
  end

  gbrf_axis u_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .invert   (1'b1),
    .lim      (ylim_r),
    .alpha    (alpha_r),
    .ppd      (ppd_r),
    .target   (in_data.yaw_target),
    .feedback (in_data.yaw_feedback_rev),
    .done     (y_done),
    .steps    (y_steps),
    .negative (y_neg),
    .report   (y_rep)
  );

  gbrf_axis u_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .invert   (1'b0),
    .lim      (plim_r),
    .alpha    (alpha_r),
    .ppd      (ppd_r),
    .target   (in_data.pitch_target),
    .feedback (in_data.pitch_feedback_rev),
    .done     (p_done),
    .steps    (p_steps),
    .negative (p_neg),
    .report   (p_rep)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 8'd0;
      due_r       <= 1'b0;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        tick_r <= due_nxt ? 8'd0 : tick_inc;
        due_r  <= due_nxt;
      end
      if (state_r == S_LP_W && y_done) begin
        loaded_r <= 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_r.yaw_steps      <= y_steps;
      out_r.yaw_negative   <= y_neg;
      out_r.pitch_steps    <= p_steps;
      out_r.pitch_negative <= p_neg;
      out_r.report_due     <= due_r;
      out_r.report_yaw     <= due_r ? y_rep : 16'sd0;
      out_r.report_pitch   <= due_r ? p_rep : 16'sd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // both axes run the same bit counts, so their multipliers finish together
  a_axes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    y_done == p_done)
    else $error("axis multipliers out of step");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.report_due) |->
      (out_r.report_yaw == 16'sd0 && out_r.report_pitch == 16'sd0))
    else $error("report fields set on a non-report tick");

  a_dir_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.yaw_negative || out_r.pitch_negative)) |->
      ((!out_r.yaw_negative || out_r.yaw_steps != 16'd0) &&
       (!out_r.pitch_negative || out_r.pitch_steps != 16'd0)))
    else $error("direction bit set with zero magnitude");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    y_done |-> (state_r == S_LP_W || state_r == S_PU_W || state_r == S_RP_W))
    else $error("multiplier finished outside a wait state");

endmodule
`default_nettype wire

[verif/tb_two_axis_gimbal_reference_filter.sv]
`timescale 1ns / 100ps

module tb_two_axis_gimbal_reference_filter;
  import gbrf_pkg::*;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        exp_known;
    in_item_t    stim;
    out_item_t   exp;
    logic [2:0]  reg_idx;
    logic [23:0] reg_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_ALPHA;
  logic [23:0] cfg_data = '0;

  // predictor copy of the registers and filter state
  logic [15:0] alpha_q16;
  logic [23:0] ppd_q16;
  logic [14:0] yaw_lim;
  logic [14:0] pitch_lim;
  logic [7:0]  rpt_period;
  longint      filt_yaw;
  longint      filt_pitch;
  bit          filt_loaded;
  logic [7:0]  ticks_since_report;

  out_item_t results_due[$];
  int        err_cnt = 0;
  int        n_ticks = 0;
  int        n_reports = 0;
  int        n_checked = 0;
  int        n_cfg = 0;
  int        tx_idle_pct = 20;
  int        rx_idle_pct = 71;
  bit        pressure_go = 1'b0;
  logic      rx_hold = 1'b0;

  two_axis_gimbal_reference_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_half_away(input longint v, input int s);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lim);
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic longint smooth(input longint last, input longint target_q8);
    longint a;
    a = alpha_q16;
    return last + round_half_away((target_q8 * 512 - last) * a, 16);
  endfunction

  // {direction, saturated magnitude} of the pulse target for a Q.17 angle
  function automatic logic [16:0] pulse_of(input longint angle_q17);
    longint ppd;
    longint p;
    longint mag;
    ppd = ppd_q16;
    p = round_half_away(angle_q17 * ppd, 33);
    mag = (p < 0) ? -p : p;
    return {p < 0, (mag > 65535) ? 16'hFFFF : mag[15:0]};
  endfunction

  function automatic out_item_t predict_tick(input in_item_t t);
    longint      yt;
    longint      pt;
    longint      yfb;
    longint      pfb;
    longint      ry;
    longint      rp;
    logic [16:0] yp;
    logic [16:0] pp;
    out_item_t   r;
    yt = clamp_to(t.yaw_target, yaw_lim);
    pt = clamp_to(t.pitch_target, pitch_lim);
    yfb = t.yaw_feedback_rev;
    pfb = t.pitch_feedback_rev;
    if (!filt_loaded) begin
      filt_yaw = yt * 512;
      filt_pitch = pt * 512;
      filt_loaded = 1'b1;
    end else begin
      filt_yaw = smooth(filt_yaw, yt);
      filt_pitch = smooth(filt_pitch, pt);
    end
    // yaw runs reversed on the motor
    yp = pulse_of(-filt_yaw);
    pp = pulse_of(filt_pitch);
    r = '0;
    r.yaw_steps = yp[15:0];
    r.yaw_negative = yp[16];
    r.pitch_steps = pp[15:0];
    r.pitch_negative = pp[16];
    ticks_since_report = ticks_since_report + 8'd1;
    if (ticks_since_report >= rpt_period) begin
      ry = clamp_to(round_half_away(-yfb * 360, 8), yaw_lim);
      rp = clamp_to(round_half_away(pfb * 360, 8), pitch_lim);
      ticks_since_report = '0;
      r.report_due = 1'b1;
      r.report_yaw = ry[15:0];
      r.report_pitch = rp[15:0];
    end
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic signed [23:0] yt, pt,
                                        input logic signed [31:0] yf, pf);
    dir_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.stim.yaw_target = yt;
    r.stim.pitch_target = pt;
    r.stim.yaw_feedback_rev = yf;
    r.stim.pitch_feedback_rev = pf;
    return r;
  endfunction

  // rows where no pulses come out, so only the report fields are nonzero
  function automatic dir_row_t known_row(input logic signed [23:0] yt, pt,
                                         input logic signed [31:0] yf, pf,
                                         input logic due,
                                         input logic signed [15:0] ry, rp);
    dir_row_t r;
    r = tick_row(yt, pt, yf, pf);
    r.exp_known = 1'b1;
    r.exp.report_due = due;
    r.exp.report_yaw = ry;
    r.exp.report_pitch = rp;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [2:0] idx, input logic [23:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic signed [23:0] rand_target(input int lim);
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'(int'($urandom_range(0, 2 * lim + 200)) - lim - 100);
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'(int'($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_feedback();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return int'($urandom_range(0, 50000)) - 25000;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val, input bit more);
    while (results_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ALPHA:     alpha_q16 = val[15:0];
      CFG_PPD:       ppd_q16 = val;
      CFG_YAW_LIM:   yaw_lim = val[14:0];
      CFG_PITCH_LIM: pitch_lim = val[14:0];
      CFG_PERIOD:    rpt_period = val[7:0];
      default: ;
    endcase
    n_cfg++;
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input in_item_t it, input bit known, input out_item_t fixed,
                           input bit more);
    out_item_t predicted;
    int        gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_tick(it);
    results_due.push_back(known ? fixed : predicted);
    n_ticks++;
    if (predicted.report_due) n_reports++;
    gap = 0;
    if (more) while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (!more || gap != 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        err_cnt++;
        $display("%0t: result %h with nothing expected", $time, out_data);
      end else begin
        want = results_due.pop_front();
        n_checked++;
        check_field("yaw_steps", want.yaw_steps, out_data.yaw_steps);
        check_field("yaw_negative", want.yaw_negative, out_data.yaw_negative);
        check_field("pitch_steps", want.pitch_steps, out_data.pitch_steps);
        check_field("pitch_negative", want.pitch_negative, out_data.pitch_negative);
        check_field("report_due", want.report_due, out_data.report_due);
        check_field("report_yaw", want.report_yaw, out_data.report_yaw);
        check_field("report_pitch", want.report_pitch, out_data.report_pitch);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main
    dir_row_t    dir_rows[$];
    in_item_t    it;
    bit          more;
    logic [15:0] c_alpha;
    logic [23:0] c_ppd;
    logic [14:0] c_ylim;
    logic [14:0] c_plim;
    logic [7:0]  c_period;

    alpha_q16 = ALPHA_RESET;
    ppd_q16 = PPD_RESET;
    yaw_lim = YAW_LIM_RESET;
    pitch_lim = PITCH_LIM_RESET;
    rpt_period = PERIOD_RESET;
    filt_yaw = 0;
    filt_pitch = 0;
    filt_loaded = 1'b0;
    ticks_since_report = '0;

    // defaults after reset, zero targets keep the filter at zero
    dir_rows.push_back(known_row(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 0, 0));
    dir_rows.push_back(known_row(0, 0, 0, 0, 1'b0, 0, 0));
    dir_rows.push_back(known_row(0, 0, -32'sd1, -32'sd1, 1'b0, 0, 0));
    dir_rows.push_back(known_row(0, 0, 32'sd16, -32'sd16, 1'b0, 0, 0));
    dir_rows.push_back(known_row(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 1'b1,
                                 -16'sd30720, -16'sd23040));
    // targets past the limits, then targets near zero
    dir_rows.push_back(tick_row(24'sh7FFFFF, 24'sh800000, 32'sd16, -32'sd16));
    dir_rows.push_back(tick_row(24'sh800000, 24'sh7FFFFF, -32'sd1, 0));
    dir_rows.push_back(tick_row(24'sd1, -24'sd1, 32'sh40000000, 32'shC0000000));
    dir_rows.push_back(tick_row(-24'sd2, 24'sd255, 32'sd1, -32'sd1));
    // report on a half-way rounding point
    dir_rows.push_back(tick_row(24'sh5A5A5A, 24'shA5A5A5, 32'sd16, -32'sd16));
    dir_rows.push_back(reg_row(CFG_ALPHA, 24'h00FFFF));
    dir_rows.push_back(reg_row(CFG_PPD, 24'hFFFFFF));
    dir_rows.push_back(reg_row(CFG_YAW_LIM, 24'h007FFF));
    dir_rows.push_back(reg_row(CFG_PITCH_LIM, 24'h007FFF));
    dir_rows.push_back(reg_row(CFG_PERIOD, 24'd1));
    dir_rows.push_back(tick_row(24'sh7FFFFF, 24'sh800000, 32'sh7FFFFFFF, 32'sh80000000));
    dir_rows.push_back(tick_row(24'sh800000, 24'sh7FFFFF, 32'sh80000000, 32'sh7FFFFFFF));
    dir_rows.push_back(reg_row(CFG_ALPHA, 24'd0));
    dir_rows.push_back(reg_row(CFG_PPD, 24'd0));
    // zero pulses must not set the direction bits
    dir_rows.push_back(known_row(24'sh7FFFFF, 24'sh800000, 0, 0, 1'b1, 0, 0));
    dir_rows.push_back(reg_row(CFG_PPD, 24'hFFFFFF));
    // alpha zero: filter holds whatever it was loaded with
    dir_rows.push_back(tick_row(24'sh800000, 24'sh7FFFFF, 32'sd12345, -32'sd12345));
    dir_rows.push_back(tick_row(0, 0, 32'sd700, 32'sd700));
    dir_rows.push_back(reg_row(CFG_PERIOD, 24'd255));
    dir_rows.push_back(reg_row(CFG_YAW_LIM, 24'd0));
    dir_rows.push_back(reg_row(CFG_PITCH_LIM, 24'd0));
    dir_rows.push_back(tick_row(24'sd3000, -24'sd3000, 32'sd5000, -32'sd5000));
    dir_rows.push_back(tick_row(24'sh7FFFFF, 24'sh800000, 32'sh7FFFFFFF, 32'sh80000000));
    dir_rows.push_back(tick_row(-24'sd77, 24'sd77, -32'sd900, 32'sd900));
    // count already past the new period, next tick reports
    dir_rows.push_back(reg_row(CFG_PERIOD, 24'd2));
    dir_rows.push_back(tick_row(24'sd100, 24'sd100, 32'sd100, 32'sd100));
    dir_rows.push_back(reg_row(CFG_PERIOD, 24'd0));
    dir_rows.push_back(tick_row(24'sd5, -24'sd5, 32'sd3, -32'sd3));
    dir_rows.push_back(tick_row(-24'sd5, 24'sd5, -32'sd3, 32'sd3));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < dir_rows.size(); k++) begin
      more = (k + 1 < dir_rows.size()) && (dir_rows[k + 1].kind == dir_rows[k].kind);
      if (dir_rows[k].kind == ROW_CFG)
        write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val, more);
      else
        send_tick(dir_rows[k].stim, dir_rows[k].exp_known, dir_rows[k].exp, more);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      c_alpha = 16'($urandom_range(0, 65535));
      c_ppd = 24'($urandom_range(0, 24'hFFFFFF));
      c_ylim = 15'($urandom_range(0, 32767));
      c_plim = 15'($urandom_range(0, 32767));
      c_period = 8'($urandom_range(1, 12));
      case (ph)
        0: begin
          c_alpha = ALPHA_RESET;
          c_ppd = PPD_RESET;
          c_ylim = YAW_LIM_RESET;
          c_plim = PITCH_LIM_RESET;
          c_period = PERIOD_RESET;
        end
        1: begin
          c_alpha = 16'hFFFF;
          c_ppd = 24'hFFFFFF;
          c_ylim = 15'h7FFF;
          c_plim = 15'h7FFF;
          c_period = 8'd1;
        end
        4: begin
          c_alpha = 16'd1;
          c_ppd = 24'hFFFFFF;
          c_ylim = 15'($urandom_range(0, 512));
          c_plim = 15'($urandom_range(0, 512));
          c_period = 8'd255;
        end
        default: ;
      endcase
      write_reg(CFG_ALPHA, 24'(c_alpha), 1'b1);
      write_reg(CFG_PPD, c_ppd, 1'b1);
      write_reg(CFG_YAW_LIM, 24'(c_ylim), 1'b1);
      write_reg(CFG_PITCH_LIM, 24'(c_plim), 1'b1);
      write_reg(CFG_PERIOD, 24'(c_period), 1'b0);
      if (ph == 2) pressure_go = 1'b1;
      for (int i = 0; i < 85; i++) begin
        it.yaw_target = rand_target(int'(yaw_lim));
        it.pitch_target = rand_target(int'(pitch_lim));
        it.yaw_feedback_rev = rand_feedback();
        it.pitch_feedback_rev = rand_feedback();
        send_tick(it, 1'b0, '0, i != 84);
      end
    end

    while (results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("checked %0d results from %0d requests, %0d of them feedback reports",
             n_checked, n_ticks, n_reports);
    $display("%0d register writes, three idle mixes and one long output stall", n_cfg);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
